>>> sv/assert_macros.svh
// Assertion macros used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define AST_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that also holds across reset.
`define AST_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> sv/i2c_mbe_pkg.sv
// Types and constants of the I2C master bit engine.
`default_nettype none

package i2c_mbe_pkg;

  localparam int unsigned CNT_W = 16;
  localparam int unsigned REG_W = 16;
  localparam int unsigned BIT_W = 4;
  localparam logic [BIT_W-1:0] BITS_PER_BYTE = BIT_W'(8);

  typedef enum logic [2:0] {
    ACT_TICK  = 3'd0,
    ACT_START = 3'd1,
    ACT_STOP  = 3'd2,
    ACT_WRITE = 3'd3,
    ACT_READ  = 3'd4,
    ACT_ACK   = 3'd5,
    ACT_NACK  = 3'd6,
    ACT_NONE  = 3'd7
  } action_t;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START_A = 4'd1,
    PH_START_B = 4'd2,
    PH_STOP_A  = 4'd3,
    PH_STOP_B  = 4'd4,
    PH_DRIVE   = 4'd5,
    PH_RELEASE = 4'd6,
    PH_WAIT    = 4'd7,
    PH_HIGH    = 4'd8,
    PH_LOW     = 4'd9
  } phase_t;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_NOACK   = 2'd1;
  localparam logic [1:0] ERR_TIMEOUT = 2'd2;

  localparam logic CFG_HALF    = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [REG_W-1:0] HALF_RESET    = REG_W'(50);
  localparam logic [REG_W-1:0] TIMEOUT_RESET = REG_W'(1000);

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] write_data;
    logic       scl_in;
    logic       sda_in;
  } in_beat_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic [1:0] error_code;
  } out_beat_t;

endpackage

`default_nettype wire

>>> sv/i2c_master_bit_engine_core.sv
// I2C master bit engine: tick-driven start/stop/byte/ack sequencer, one result per tick.
//
// Usage: each input beat on in_* is one bus tick carrying the sampled SCL/SDA
// levels and an optional command (start, stop, write, read, ack, nack).
// Commands are taken only when the engine is idle; otherwise they are ignored.
// Every input beat yields exactly one output beat with the open-drain drives,
// busy/done flags, the last read byte and the error code.
// Results are registered in out_r, or in the skid stage while the output is stalled.
// Throughput: one beat per cycle while in_stall is low; the state update is one
// register-to-register pass and the output register plus a one-entry skid stage
// decouple the sides. Stall: while the output is stalled the skid stage takes one
// more beat, then in_stall rises until the output drains. Nothing is dropped.
// Reset (rst_n low, synchronous): engine idle, lines released, counters and
// error cleared, half period 50 ticks, stretch timeout 1000 ticks.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx at once
// (0: half period ticks, 1: stretch timeout ticks); zero acts as one.
`default_nettype none

module i2c_master_bit_engine_core import i2c_mbe_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_beat_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_beat_t             out_data,
  input  wire logic             cfg_we,
  input  wire logic             cfg_idx,
  input  wire logic [REG_W-1:0] cfg_wdata
);

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    sat_inc = (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  function automatic logic cnt_hit(input logic [CNT_W-1:0] c, input logic [REG_W-1:0] lim);
    logic [REG_W-1:0] l;
    l = (lim == '0) ? REG_W'(1) : lim;
    cnt_hit = ({1'b0, c} >= {1'b0, l}) || (c == CNT_MAX);
  endfunction

  logic [REG_W-1:0] half_r, tmo_r;
  phase_t           phase_r, phase_nxt;
  action_t          cmd_r, cmd_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic [7:0]       shift_r, shift_nxt;
  logic [CNT_W-1:0] dly_r, dly_nxt;
  logic [CNT_W-1:0] wait_r, wait_nxt;
  logic             scl_low_r, scl_low_nxt;
  logic             sda_low_r, sda_low_nxt;
  logic [1:0]       err_r, err_nxt;
  logic [7:0]       rd_r, rd_nxt;
  logic             done_nxt;

  out_beat_t        out_r, skid_r, res;
  logic             out_v_r, skid_v_r;
  logic             in_fire, out_fire;

  logic [CNT_W-1:0] dly_inc, wait_inc;
  logic             dly_hit, wait_hit;
  logic             cmd_ok;
  action_t          act;

  assign act      = action_t'(in_data.action);
  assign cmd_ok   = (act != ACT_TICK) && (act != ACT_NONE);
  assign dly_inc  = sat_inc(dly_r);
  assign wait_inc = sat_inc(wait_r);
  assign dly_hit  = cnt_hit(dly_inc, half_r);
  assign wait_hit = cnt_hit(wait_inc, tmo_r);

  assign in_stall = skid_v_r;
  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_v_r && !out_stall;

  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_IDLE: begin
        if (cmd_ok) begin
          if (act == ACT_START) phase_nxt = PH_START_A;
          else if (act == ACT_STOP) phase_nxt = PH_STOP_A;
          else phase_nxt = PH_DRIVE;
        end
      end
      PH_START_A: if (dly_hit) phase_nxt = PH_START_B;
      PH_START_B: if (dly_hit) phase_nxt = PH_IDLE;
      PH_STOP_A:  if (dly_hit) phase_nxt = PH_STOP_B;
      PH_STOP_B:  if (dly_hit) phase_nxt = PH_IDLE;
      PH_DRIVE:   phase_nxt = PH_RELEASE;
      PH_RELEASE: phase_nxt = PH_WAIT;
      PH_WAIT: begin
        if (in_data.scl_in) phase_nxt = PH_HIGH;
        else if (wait_hit) phase_nxt = PH_IDLE;
      end
      PH_HIGH: begin
        if (dly_hit) begin
          if (cmd_r == ACT_WRITE) begin
            phase_nxt = (bit_r < BITS_PER_BYTE) ? PH_DRIVE : PH_IDLE;
          end else if (cmd_r == ACT_READ) begin
            phase_nxt = PH_LOW;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_LOW: begin
        if (dly_hit) phase_nxt = (bit_r >= BITS_PER_BYTE) ? PH_IDLE : PH_DRIVE;
      end
      default: phase_nxt = PH_IDLE;
    endcase
  end

  always_comb begin
    cmd_nxt     = cmd_r;
    bit_nxt     = bit_r;
    shift_nxt   = shift_r;
    dly_nxt     = dly_r;
    wait_nxt    = wait_r;
    scl_low_nxt = scl_low_r;
    sda_low_nxt = sda_low_r;
    err_nxt     = err_r;
    rd_nxt      = rd_r;
    done_nxt    = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (cmd_ok) begin
          cmd_nxt  = act;
          err_nxt  = ERR_OK;
          bit_nxt  = '0;
          dly_nxt  = '0;
          wait_nxt = '0;
          if (act == ACT_START) begin
            scl_low_nxt = 1'b0;
            sda_low_nxt = 1'b0;
          end else if (act == ACT_STOP) begin
            sda_low_nxt = 1'b1;
          end else begin
            shift_nxt = (act == ACT_WRITE) ? in_data.write_data : 8'h00;
          end
        end
      end
      PH_START_A, PH_STOP_A: begin
        dly_nxt = dly_inc;
        if (dly_hit) begin
          dly_nxt = '0;
          if (phase_r == PH_START_A) sda_low_nxt = 1'b1;
          else scl_low_nxt = 1'b0;
        end
      end
      PH_START_B, PH_STOP_B: begin
        dly_nxt = dly_inc;
        if (dly_hit) begin
          if (phase_r == PH_START_B) scl_low_nxt = 1'b1;
          else sda_low_nxt = 1'b0;
          err_nxt  = ERR_OK;
          done_nxt = 1'b1;
        end
      end
      PH_DRIVE: begin
        if (cmd_r == ACT_WRITE && bit_r < BITS_PER_BYTE) sda_low_nxt = !shift_r[7];
        else if (cmd_r == ACT_ACK) sda_low_nxt = 1'b1;
        else sda_low_nxt = 1'b0;
      end
      PH_RELEASE: begin
        scl_low_nxt = 1'b0;
        wait_nxt    = '0;
      end
      PH_WAIT: begin
        if (in_data.scl_in) begin
          dly_nxt = '0;
        end else begin
          wait_nxt = wait_inc;
          if (wait_hit) begin
            err_nxt  = ERR_TIMEOUT;
            done_nxt = 1'b1;
          end
        end
      end
      PH_HIGH: begin
        dly_nxt = dly_inc;
        if (dly_hit) begin
          scl_low_nxt = 1'b1;
          if (cmd_r == ACT_WRITE) begin
            if (bit_r < BITS_PER_BYTE) begin
              shift_nxt = {shift_r[6:0], 1'b0};
              bit_nxt   = bit_r + BIT_W'(1);
            end else begin
              err_nxt  = in_data.sda_in ? ERR_NOACK : ERR_OK;
              done_nxt = 1'b1;
            end
          end else if (cmd_r == ACT_READ) begin
            shift_nxt = {shift_r[6:0], in_data.sda_in};
            bit_nxt   = bit_r + BIT_W'(1);
            dly_nxt   = '0;
          end else begin
            err_nxt  = ERR_OK;
            done_nxt = 1'b1;
          end
        end
      end
      PH_LOW: begin
        dly_nxt = dly_inc;
        if (dly_hit && bit_r >= BITS_PER_BYTE) begin
          rd_nxt   = shift_r;
          err_nxt  = ERR_OK;
          done_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.scl_drive_low = scl_low_nxt;
    res.sda_drive_low = sda_low_nxt;
    res.busy_res      = (phase_nxt != PH_IDLE);
    res.done_res      = done_nxt;
    res.read_data     = rd_nxt;
    res.error_code    = err_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r    <= HALF_RESET;
      tmo_r     <= TIMEOUT_RESET;
      phase_r   <= PH_IDLE;
      cmd_r     <= ACT_TICK;
      bit_r     <= '0;
      shift_r   <= '0;
      dly_r     <= '0;
      wait_r    <= '0;
      scl_low_r <= 1'b0;
      sda_low_r <= 1'b0;
      err_r     <= ERR_OK;
      rd_r      <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == CFG_HALF) half_r <= cfg_wdata;
        else tmo_r <= cfg_wdata;
      end
      if (in_fire) begin
        phase_r   <= phase_nxt;
        cmd_r     <= cmd_nxt;
        bit_r     <= bit_nxt;
        shift_r   <= shift_nxt;
        dly_r     <= dly_nxt;
        wait_r    <= wait_nxt;
        scl_low_r <= scl_low_nxt;
        sda_low_r <= sda_low_nxt;
        err_r     <= err_nxt;
        rd_r      <= rd_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_fire) skid_v_r <= 1'b0;
    end else if (in_fire) begin
      if (out_v_r && !out_fire) skid_v_r <= 1'b1;
      else out_v_r <= 1'b1;
    end else if (out_fire) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (out_fire) out_r <= skid_r;
    end else if (in_fire) begin
      if (out_v_r && !out_fire) skid_r <= res;
      else out_r <= res;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> sv/i2c_mbe_checker.sv
// Port-level assertions for the I2C master bit engine, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module i2c_mbe_checker import i2c_mbe_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_stall,
  input wire logic             out_valid,
  input wire logic             out_stall,
  input wire out_beat_t        out_data
);

  logic in_fire;
  assign in_fire = in_valid && !in_stall;

  `AST_NEXT(a_beat_out, clk, rst_n, in_fire, out_valid)
  `AST_IMPLY(a_done_idle, clk, rst_n, out_valid && out_data.done_res, !out_data.busy_res)
  `AST_IMPLY(a_err_code, clk, rst_n, out_valid, out_data.error_code != 2'd3)
  `AST_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))
  `AST_NEXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid && !in_stall)

endmodule

bind i2c_master_bit_engine_core i2c_mbe_checker u_i2c_mbe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

>>> tb/sv/tb_top.sv
// Testbench for the I2C master bit engine: bus-tick stimulus with a tick-level status predictor.
`timescale 1ns / 100ps

module tb_top;
  import i2c_mbe_pkg::*;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_idx = CFG_HALF;
  logic [REG_W-1:0] cfg_wdata = '0;

  // engine predictor state
  phase_t           eng_ph = PH_IDLE;
  action_t          eng_cmd = ACT_TICK;
  logic [BIT_W-1:0] eng_bit = '0;
  logic [7:0]       eng_shift = '0;
  logic [CNT_W-1:0] eng_dly = '0;
  logic [CNT_W-1:0] eng_wait = '0;
  logic             eng_scl = 1'b0;
  logic             eng_sda = 1'b0;
  logic [1:0]       eng_err = ERR_OK;
  logic [7:0]       eng_rbyte = '0;
  logic             eng_done = 1'b0;
  logic [REG_W-1:0] eng_half = HALF_RESET;
  logic [REG_W-1:0] eng_tmo = TIMEOUT_RESET;

  out_beat_t        engine_status_q[$];
  int               mismatches = 0;
  bit               sender_gaps = 1'b1;
  bit               stall_on = 1'b1;
  bit               hold_req = 1'b0;
  int               stretch_pct = 20;
  int               sda_mode = 2;

  always #5 clk = ~clk;

  i2c_master_bit_engine_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  function automatic int pick_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
  endfunction

  // saturating count; top bit flags limit reached (zero limit acts as one)
  function automatic logic [CNT_W:0] count_up(logic [CNT_W-1:0] cnt, logic [REG_W-1:0] lim);
    logic [CNT_W-1:0] nxt;
    logic [CNT_W-1:0] top;
    top = (lim == '0) ? CNT_W'(1) : CNT_W'(lim);
    nxt = (cnt == '1) ? cnt : cnt + 1'b1;
    return {(nxt >= top) || (nxt == '1), nxt};
  endfunction

  task automatic end_cmd(input logic [1:0] code);
    eng_ph = PH_IDLE;
    eng_err = code;
    eng_done = 1'b1;
  endtask

  task automatic step_engine(input in_beat_t b, output out_beat_t r);
    logic [CNT_W:0] c;
    eng_done = 1'b0;
    case (eng_ph)
      PH_IDLE: if (b.action >= ACT_START && b.action <= ACT_NACK) begin
        eng_cmd = action_t'(b.action);
        eng_err = ERR_OK;
        eng_bit = '0;
        eng_dly = '0;
        eng_wait = '0;
        if (eng_cmd == ACT_START) begin
          eng_scl = 1'b0;
          eng_sda = 1'b0;
          eng_ph = PH_START_A;
        end else if (eng_cmd == ACT_STOP) begin
          eng_sda = 1'b1;
          eng_ph = PH_STOP_A;
        end else begin
          eng_shift = (eng_cmd == ACT_WRITE) ? b.write_data : 8'h00;
          eng_ph = PH_DRIVE;
        end
      end
      PH_START_A: begin
        c = count_up(eng_dly, eng_half);
        eng_dly = c[CNT_W-1:0];
        if (c[CNT_W]) begin
          eng_sda = 1'b1;
          eng_dly = '0;
          eng_ph = PH_START_B;
        end
      end
      PH_START_B: begin
        c = count_up(eng_dly, eng_half);
        eng_dly = c[CNT_W-1:0];
        if (c[CNT_W]) begin
          eng_scl = 1'b1;
          end_cmd(ERR_OK);
        end
      end
      PH_STOP_A: begin
        c = count_up(eng_dly, eng_half);
        eng_dly = c[CNT_W-1:0];
        if (c[CNT_W]) begin
          eng_scl = 1'b0;
          eng_dly = '0;
          eng_ph = PH_STOP_B;
        end
      end
      PH_STOP_B: begin
        c = count_up(eng_dly, eng_half);
        eng_dly = c[CNT_W-1:0];
        if (c[CNT_W]) begin
          eng_sda = 1'b0;
          end_cmd(ERR_OK);
        end
      end
      PH_DRIVE: begin
        if (eng_cmd == ACT_WRITE && eng_bit < BITS_PER_BYTE) eng_sda = ~eng_shift[7];
        else eng_sda = (eng_cmd == ACT_ACK);
        eng_ph = PH_RELEASE;
      end
      PH_RELEASE: begin
        eng_scl = 1'b0;
        eng_wait = '0;
        eng_ph = PH_WAIT;
      end
      PH_WAIT: begin
        if (b.scl_in) begin
          eng_dly = '0;
          eng_ph = PH_HIGH;
        end else begin
          c = count_up(eng_wait, eng_tmo);
          eng_wait = c[CNT_W-1:0];
          if (c[CNT_W]) end_cmd(ERR_TIMEOUT);
        end
      end
      PH_HIGH: begin
        c = count_up(eng_dly, eng_half);
        eng_dly = c[CNT_W-1:0];
        if (c[CNT_W]) begin
          eng_scl = 1'b1;
          if (eng_cmd == ACT_WRITE && eng_bit < BITS_PER_BYTE) begin
            eng_shift = eng_shift << 1;
            eng_bit = eng_bit + 1'b1;
            eng_ph = PH_DRIVE;
          end else if (eng_cmd == ACT_WRITE) begin
            end_cmd(b.sda_in ? ERR_NOACK : ERR_OK);
          end else if (eng_cmd == ACT_READ) begin
            eng_shift = {eng_shift[6:0], b.sda_in};
            eng_bit = eng_bit + 1'b1;
            eng_dly = '0;
            eng_ph = PH_LOW;
          end else begin
            end_cmd(ERR_OK);
          end
        end
      end
      PH_LOW: begin
        c = count_up(eng_dly, eng_half);
        eng_dly = c[CNT_W-1:0];
        if (c[CNT_W]) begin
          if (eng_bit >= BITS_PER_BYTE) begin
            eng_rbyte = eng_shift;
            end_cmd(ERR_OK);
          end else begin
            eng_ph = PH_DRIVE;
          end
        end
      end
      default: eng_ph = PH_IDLE;
    endcase
    r.scl_drive_low = eng_scl;
    r.sda_drive_low = eng_sda;
    r.busy_res = (eng_ph != PH_IDLE);
    r.done_res = eng_done;
    r.read_data = eng_rbyte;
    r.error_code = eng_err;
  endtask

  // slave side: stretches SCL at random while the engine waits for it
  function automatic in_beat_t make_tick(logic [2:0] act);
    in_beat_t b;
    b.action = act;
    b.write_data = 8'($urandom);
    b.scl_in = (eng_ph == PH_WAIT) ? ($urandom_range(1, 100) > stretch_pct) : 1'($urandom);
    b.sda_in = (sda_mode > 1) ? 1'($urandom) : sda_mode[0];
    return b;
  endfunction

  function automatic logic [2:0] next_action();
    if (eng_ph == PH_IDLE) begin
      if ($urandom_range(0, 6) != 0) return 3'($urandom_range(ACT_START, ACT_NACK));
      return $urandom_range(0, 1) ? ACT_TICK : ACT_NONE;
    end
    return ($urandom_range(0, 7) == 0) ? 3'($urandom) : ACT_TICK;
  endfunction

  task automatic send_tick(input in_beat_t b);
    out_beat_t r;
    int gap;
    gap = (sender_gaps && $urandom_range(0, 3) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_stall);
    step_engine(b, r);
    engine_status_q.push_back(r);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (engine_status_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [REG_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HALF) eng_half = val;
    else eng_tmo = val;
  endtask

  task automatic tick_until_idle();
    while (eng_ph != PH_IDLE) send_tick(make_tick(next_action()));
  endtask

  task automatic run_cmd(input action_t act, input logic [7:0] data);
    in_beat_t b;
    b = make_tick(act);
    b.write_data = data;
    send_tick(b);
    tick_until_idle();
  endtask

  task automatic test_reset_values();
    send_tick(make_tick(ACT_TICK));
    send_tick(make_tick(ACT_NONE));
    stretch_pct = 10;
    run_cmd(ACT_START, 8'h00);
  endtask

  task automatic test_each_command();
    write_reg(CFG_HALF, '0);
    write_reg(CFG_TIMEOUT, REG_W'(1000));
    stretch_pct = 30;
    sda_mode = 0;
    run_cmd(ACT_START, 8'h00);
    run_cmd(ACT_WRITE, 8'hA5);
    run_cmd(ACT_READ, 8'h00);
    sda_mode = 1;
    run_cmd(ACT_WRITE, 8'hFF);
    run_cmd(ACT_READ, 8'h00);
    sda_mode = 2;
    run_cmd(ACT_WRITE, 8'h00);
    run_cmd(ACT_READ, 8'h00);
    run_cmd(ACT_ACK, 8'h00);
    run_cmd(ACT_NACK, 8'h00);
    run_cmd(ACT_STOP, 8'h00);
  endtask

  task automatic test_stretch_timeout();
    write_reg(CFG_HALF, REG_W'(2));
    write_reg(CFG_TIMEOUT, REG_W'(3));
    stretch_pct = 100;
    run_cmd(ACT_READ, 8'h00);
    run_cmd(ACT_WRITE, 8'h3C);
    write_reg(CFG_TIMEOUT, '0);
    run_cmd(ACT_ACK, 8'h00);
    stretch_pct = 50;
    write_reg(CFG_TIMEOUT, REG_W'(2));
    run_cmd(ACT_NACK, 8'h00);
    run_cmd(ACT_READ, 8'h00);
    stretch_pct = 20;
    run_cmd(ACT_STOP, 8'h00);
  endtask

  task automatic test_counter_limits();
    sender_gaps = 1'b0;
    stall_on = 1'b0;
    stretch_pct = 0;
    write_reg(CFG_HALF, REG_W'(12));
    send_tick(make_tick(ACT_START));
    repeat (5) send_tick(make_tick(ACT_TICK));
    // shorter half period lands mid-command
    write_reg(CFG_HALF, REG_W'(1));
    tick_until_idle();
    write_reg(CFG_TIMEOUT, REG_W'(20));
    stretch_pct = 100;
    run_cmd(ACT_WRITE, 8'h81);
    stretch_pct = 20;
    sender_gaps = 1'b1;
    stall_on = 1'b1;
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < 120; n++) begin
      if (n % 40 == 0) begin
        write_reg(CFG_HALF, REG_W'($urandom_range(0, 3)));
        write_reg(CFG_TIMEOUT, ($urandom_range(0, 3) == 0) ?
                  REG_W'($urandom_range(0, 2)) : REG_W'($urandom_range(4, 40)));
        stretch_pct = $urandom_range(0, 60);
        sda_mode = 2;
        sender_gaps = (n != 0);
        stall_on = (n != 0);
      end
      if (n == 80) hold_req = 1'b1;
      send_tick(make_tick(next_action()));
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : result_check
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (engine_status_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none got %h", $time, out_data);
        mismatches++;
      end else begin
        want = engine_status_q.pop_front();
        check_field("scl_drive_low", 8'(want.scl_drive_low), 8'(out_data.scl_drive_low));
        check_field("sda_drive_low", 8'(want.sda_drive_low), 8'(out_data.sda_drive_low));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
        check_field("read_data", want.read_data, out_data.read_data);
        check_field("error_code", 8'(want.error_code), 8'(out_data.error_code));
      end
    end
  end

  initial begin : out_side
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = 200;
      end else if (stall_left == 0 && stall_on && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  initial begin : watchdog
    #(20_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_each_command();
    test_stretch_timeout();
    test_counter_limits();
    test_random_traffic();
    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> i2c_master_bit_engine_core.f
+incdir+sv
sv/i2c_mbe_pkg.sv
sv/i2c_master_bit_engine_core.sv
sv/i2c_mbe_checker.sv
tb/sv/tb_top.sv
